>>> rtl/hrsp_pkg.sv
// Shared types and constants for the HTTP request stream parser.
package hrsp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_METHOD   = 7'b0000001,
    PH_PATH     = 7'b0000010,
    PH_PROTOCOL = 7'b0000100,
    PH_HEADERS  = 7'b0001000,
    PH_BODY     = 7'b0010000,
    PH_DONE     = 7'b0100000,
    PH_ERROR    = 7'b1000000
  } phase_t;

  // Header value sub-phase.
  typedef enum logic [1:0] {
    VP_NAME = 2'd0,
    VP_PRE  = 2'd1,
    VP_DIG  = 2'd2,
    VP_END  = 2'd3
  } value_phase_t;

  // Byte classes.
  localparam logic [2:0] CLS_DROP     = 3'd0;
  localparam logic [2:0] CLS_METHOD   = 3'd1;
  localparam logic [2:0] CLS_PATH     = 3'd2;
  localparam logic [2:0] CLS_PROTOCOL = 3'd3;
  localparam logic [2:0] CLS_HEADER   = 3'd4;
  localparam logic [2:0] CLS_BODY     = 3'd5;

  // Register indexes on the config port.
  localparam logic [1:0] REG_METHOD_LIMIT   = 2'd0;
  localparam logic [1:0] REG_PATH_LIMIT     = 2'd1;
  localparam logic [1:0] REG_PROTOCOL_LIMIT = 2'd2;

  localparam logic [15:0] METHOD_LIMIT_RST   = 16'd16;
  localparam logic [15:0] PATH_LIMIT_RST     = 16'd1024;
  localparam logic [15:0] PROTOCOL_LIMIT_RST = 16'd16;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0]  NAME_LEN = 4'd14;
  localparam logic [30:0] LEN_MAX  = 31'h7fffffff;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_class;
    logic        field_end;
    logic        headers_done;
    logic        request_done;
    logic        overflow_error;
    logic [30:0] committed_length;
  } result_t;

  // Characters of "Content-Length".
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/hrsp_parse.sv
// Parser state and per-byte classification logic.
module hrsp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             start_request,
  input  logic [15:0]      method_limit,
  input  logic [15:0]      path_limit,
  input  logic [15:0]      protocol_limit,
  output hrsp_pkg::result_t res
);
  import hrsp_pkg::*;

  phase_t       phase;
  logic [15:0]  field_count;
  logic         line_nonempty;
  logic [3:0]   name_match_pos;
  logic         name_still_matches;
  value_phase_t value_phase;
  logic [30:0]  pending_value;
  logic [30:0]  length_reg;
  logic [31:0]  body_count;

  phase_t       phase_next;
  logic [15:0]  field_count_next;
  logic         line_nonempty_next;
  logic [3:0]   name_match_pos_next;
  logic         name_still_matches_next;
  value_phase_t value_phase_next;
  logic [30:0]  pending_value_next;
  logic [30:0]  length_reg_next;
  logic [31:0]  body_count_next;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  endc;
    logic [15:0] lim;
    logic [16:0] need;
    logic        digit_go;
    logic [34:0] acc;
    logic [2:0]  cls;
    logic        fend;
    logic        hdone;
    logic        rdone;
    logic        oerr;

    b        = data_byte;
    cls      = CLS_DROP;
    fend     = 1'b0;
    hdone    = 1'b0;
    rdone    = 1'b0;
    oerr     = 1'b0;
    digit_go = 1'b0;
    acc      = '0;

    if (start_request) begin
      phase_next              = PH_METHOD;
      field_count_next        = '0;
      length_reg_next         = '0;
      body_count_next         = '0;
      line_nonempty_next      = 1'b0;
      name_match_pos_next     = '0;
      name_still_matches_next = 1'b1;
      value_phase_next        = VP_NAME;
      pending_value_next      = '0;
    end else begin
      phase_next              = phase;
      field_count_next        = field_count;
      length_reg_next         = length_reg;
      body_count_next         = body_count;
      line_nonempty_next      = line_nonempty;
      name_match_pos_next     = name_match_pos;
      name_still_matches_next = name_still_matches;
      value_phase_next        = value_phase;
      pending_value_next      = pending_value;
    end

    endc = (phase_next == PH_PROTOCOL) ? CH_LF : CH_SPACE;
    lim  = (phase_next == PH_METHOD) ? method_limit :
           (phase_next == PH_PATH)   ? path_limit : protocol_limit;
    need = {1'b0, field_count_next} + 17'd2;

    case (phase_next)
      PH_METHOD, PH_PATH, PH_PROTOCOL: begin
        if (b == CH_CR) begin
          cls = CLS_DROP;
        end else if (b == endc) begin
          fend             = 1'b1;
          field_count_next = '0;
          if (phase_next == PH_METHOD) begin
            cls        = CLS_METHOD;
            phase_next = PH_PATH;
          end else if (phase_next == PH_PATH) begin
            cls        = CLS_PATH;
            phase_next = PH_PROTOCOL;
          end else begin
            cls                     = CLS_PROTOCOL;
            phase_next              = PH_HEADERS;
            line_nonempty_next      = 1'b0;
            name_match_pos_next     = '0;
            name_still_matches_next = 1'b1;
            value_phase_next        = VP_NAME;
            pending_value_next      = '0;
          end
        end else if (need > {1'b0, lim}) begin
          phase_next = PH_ERROR;
          oerr       = 1'b1;
        end else begin
          cls = (phase_next == PH_METHOD) ? CLS_METHOD :
                (phase_next == PH_PATH)   ? CLS_PATH : CLS_PROTOCOL;
          field_count_next = field_count_next + 16'd1;
        end
      end
      PH_HEADERS: begin
        if (b == CH_CR) begin
          cls = CLS_DROP;
        end else if (b == CH_LF) begin
          cls = CLS_HEADER;
          if (!line_nonempty_next) begin
            hdone           = 1'b1;
            body_count_next = '0;
            if (length_reg_next == '0) begin
              rdone      = 1'b1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_BODY;
            end
          end else begin
            if (value_phase_next != VP_NAME && name_still_matches_next)
              length_reg_next = pending_value_next;
            line_nonempty_next      = 1'b0;
            name_match_pos_next     = '0;
            name_still_matches_next = 1'b1;
            value_phase_next        = VP_NAME;
            pending_value_next      = '0;
          end
        end else begin
          cls                = CLS_HEADER;
          line_nonempty_next = 1'b1;
          if (value_phase_next == VP_NAME) begin
            if (b == CH_COLON) begin
              if (name_still_matches_next && name_match_pos_next == NAME_LEN) begin
                value_phase_next = VP_PRE;
              end else begin
                name_still_matches_next = 1'b0;
                value_phase_next        = VP_END;
              end
            end else if (name_match_pos_next < NAME_LEN &&
                         b == name_char(name_match_pos_next)) begin
              name_match_pos_next = name_match_pos_next + 4'd1;
            end else begin
              name_still_matches_next = 1'b0;
            end
          end else begin
            if (value_phase_next == VP_PRE) begin
              if (b == CH_SPACE || b == CH_TAB) begin
                value_phase_next = VP_PRE;
              end else if (b == CH_PLUS) begin
                value_phase_next = VP_DIG;
              end else if (b == CH_MINUS) begin
                pending_value_next = '0;
                value_phase_next   = VP_END;
              end else begin
                value_phase_next = VP_DIG;
                digit_go         = 1'b1;
              end
            end else if (value_phase_next == VP_DIG) begin
              digit_go = 1'b1;
            end
            if (digit_go) begin
              if (b >= CH_ZERO && b <= CH_NINE) begin
                // value * 10 + digit, saturating at 2^31-1
                acc = ({4'b0, pending_value_next} << 3) + ({4'b0, pending_value_next} << 1)
                      + {27'b0, b - CH_ZERO};
                pending_value_next = (acc > {4'b0, LEN_MAX}) ? LEN_MAX : acc[30:0];
              end else begin
                value_phase_next = VP_END;
              end
            end
          end
        end
      end
      PH_BODY: begin
        cls = CLS_BODY;
        if (body_count_next != 32'hffffffff)
          body_count_next = body_count_next + 32'd1;
        if (body_count_next >= {1'b0, length_reg_next}) begin
          rdone      = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        rdone = 1'b1;
      end
      default: begin
        phase_next = PH_ERROR;
        oerr       = 1'b1;
      end
    endcase

    res.out_byte         = b;
    res.byte_class       = cls;
    res.field_end        = fend;
    res.headers_done     = hdone;
    res.request_done     = rdone;
    res.overflow_error   = oerr;
    res.committed_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_METHOD;
      field_count        <= '0;
      line_nonempty      <= 1'b0;
      name_match_pos     <= '0;
      name_still_matches <= 1'b1;
      value_phase        <= VP_NAME;
      pending_value      <= '0;
      length_reg         <= '0;
      body_count         <= '0;
    end else if (step) begin
      phase              <= phase_next;
      field_count        <= field_count_next;
      line_nonempty      <= line_nonempty_next;
      name_match_pos     <= name_match_pos_next;
      name_still_matches <= name_still_matches_next;
      value_phase        <= value_phase_next;
      pending_value      <= pending_value_next;
      length_reg         <= length_reg_next;
      body_count         <= body_count_next;
    end
  end

endmodule

>>> rtl/http_request_stream_parser.sv
// HTTP request stream parser: takes one request byte per cycle unless stalled, and labels it.
// Each accepted byte is classified in the cycle it is accepted and its result is registered
// into the output register, or into the skid register while the output holds a stalled result;
// the two-entry output stage (output register plus skid register) thus lets a byte be taken
// while the previous result is still stalled, and in_stall rises only once both entries are
// full. The user must write field limits on the cfg port while the block is idle; the block does not enforce it.
module http_request_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [2:0]  byte_class,
  output logic        field_end,
  output logic        headers_done,
  output logic        request_done,
  output logic        overflow_error,
  output logic [30:0] committed_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hrsp_pkg::*;

  logic [15:0] method_limit;
  logic [15:0] path_limit;
  logic [15:0] protocol_limit;

  logic        accept;
  logic        take;
  result_t     new_res;
  result_t     out_res;
  result_t     skid_res;
  logic        skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      method_limit   <= METHOD_LIMIT_RST;
      path_limit     <= PATH_LIMIT_RST;
      protocol_limit <= PROTOCOL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METHOD_LIMIT:   method_limit   <= cfg_data;
        REG_PATH_LIMIT:     path_limit     <= cfg_data;
        REG_PROTOCOL_LIMIT: protocol_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  hrsp_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .data_byte      (data_byte),
    .start_request  (start_request),
    .method_limit   (method_limit),
    .path_limit     (path_limit),
    .protocol_limit (protocol_limit),
    .res            (new_res)
  );

  // Control for the output register and skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (!out_valid) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) out_res <= skid_res;
      else if (accept) out_res <= new_res;
    end else if (accept) begin
      if (!out_valid) out_res <= new_res;
      else skid_res <= new_res;
    end
  end

  assign out_byte         = out_res.out_byte;
  assign byte_class       = out_res.byte_class;
  assign field_end        = out_res.field_end;
  assign headers_done     = out_res.headers_done;
  assign request_done     = out_res.request_done;
  assign overflow_error   = out_res.overflow_error;
  assign committed_length = out_res.committed_length;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for http_request_stream_parser: byte labeling against a local predictor.
`timescale 1ns / 100ps

module testbench;
  import hrsp_pkg::*;

  // Predicts the label of every request byte and holds the labels still owed by the block.
  class request_labeler;
    logic [15:0] method_lim;
    logic [15:0] path_lim;
    logic [15:0] proto_lim;
    phase_t       phase;
    logic [15:0]  field_count;
    bit           line_nonempty;
    logic [3:0]   name_pos;
    bit           name_ok;
    value_phase_t vphase;
    logic [30:0]  pending_len;
    logic [30:0]  length_reg;
    logic [31:0]  body_count;
    string        cl_name;
    result_t      expected_q[$];
    int           errors;
    int           checked;
    int           blocks_closed;
    int           done_bytes;
    int           overflow_bytes;
    int           commits;

    function new();
      cl_name    = "Content-Length";
      method_lim = METHOD_LIMIT_RST;
      path_lim   = PATH_LIMIT_RST;
      proto_lim  = PROTOCOL_LIMIT_RST;
      restart_request();
    endfunction

    function void set_limit(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_METHOD_LIMIT:   method_lim = val;
        REG_PATH_LIMIT:     path_lim = val;
        REG_PROTOCOL_LIMIT: proto_lim = val;
        default: ;
      endcase
    endfunction

    function void restart_line();
      line_nonempty = 0;
      name_pos      = '0;
      name_ok       = 1;
      vphase        = VP_NAME;
      pending_len   = '0;
    endfunction

    function void restart_request();
      phase       = PH_METHOD;
      field_count = '0;
      length_reg  = '0;
      body_count  = '0;
      restart_line();
    endfunction

    // Name match, then the value: blanks, one sign, saturating digits.
    function void take_header_char(logic [7:0] b);
      logic [63:0] nv;
      line_nonempty = 1;
      if (vphase == VP_NAME) begin
        if (b == CH_COLON) begin
          if (name_ok && name_pos == NAME_LEN) vphase = VP_PRE;
          else begin
            name_ok = 0;
            vphase  = VP_END;
          end
        end else if (name_pos < NAME_LEN && b == cl_name[name_pos]) begin
          name_pos++;
        end else begin
          name_ok = 0;
        end
        return;
      end
      if (vphase == VP_PRE) begin
        if (b == CH_SPACE || b == CH_TAB) return;
        if (b == CH_PLUS) begin
          vphase = VP_DIG;
          return;
        end
        if (b == CH_MINUS) begin
          pending_len = '0;
          vphase      = VP_END;
          return;
        end
        vphase = VP_DIG;
      end
      if (vphase == VP_DIG) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          nv = {33'd0, pending_len} * 64'd10 + {56'd0, b - CH_ZERO};
          pending_len = (nv > {33'd0, LEN_MAX}) ? LEN_MAX : nv[30:0];
        end else begin
          vphase = VP_END;
        end
      end
    endfunction

    function void label_byte(logic [7:0] b, logic start);
      result_t     r;
      logic [2:0]  fcls;
      logic [15:0] lim;
      logic [7:0]  endc;
      phase_t      nxt;
      r = '0;
      r.out_byte = b;
      if (start) restart_request();
      case (phase)
        PH_METHOD, PH_PATH, PH_PROTOCOL: begin
          case (phase)
            PH_METHOD: begin
              fcls = CLS_METHOD; lim = method_lim; endc = CH_SPACE; nxt = PH_PATH;
            end
            PH_PATH: begin
              fcls = CLS_PATH; lim = path_lim; endc = CH_SPACE; nxt = PH_PROTOCOL;
            end
            default: begin
              fcls = CLS_PROTOCOL; lim = proto_lim; endc = CH_LF; nxt = PH_HEADERS;
            end
          endcase
          if (b == CH_CR) begin
            r.byte_class = CLS_DROP;
          end else if (b == endc) begin
            r.byte_class = fcls;
            r.field_end  = 1;
            field_count  = '0;
            phase        = nxt;
            if (nxt == PH_HEADERS) restart_line();
          end else if (({16'd0, field_count} + 32'd2) > {16'd0, lim}) begin
            phase            = PH_ERROR;
            r.overflow_error = 1;
          end else begin
            r.byte_class = fcls;
            field_count++;
          end
        end
        PH_HEADERS: begin
          if (b == CH_CR) begin
            r.byte_class = CLS_DROP;
          end else if (b == CH_LF) begin
            r.byte_class = CLS_HEADER;
            if (!line_nonempty) begin
              r.headers_done = 1;
              body_count     = '0;
              if (length_reg == 0) begin
                r.request_done = 1;
                phase          = PH_DONE;
              end else begin
                phase = PH_BODY;
              end
            end else begin
              if (vphase != VP_NAME && name_ok) begin
                length_reg = pending_len;
                commits++;
              end
              restart_line();
            end
          end else begin
            r.byte_class = CLS_HEADER;
            take_header_char(b);
          end
        end
        PH_BODY: begin
          r.byte_class = CLS_BODY;
          if (body_count != 32'hffff_ffff) body_count++;
          if (body_count >= {1'b0, length_reg}) begin
            r.request_done = 1;
            phase          = PH_DONE;
          end
        end
        PH_DONE: r.request_done = 1;
        default: begin
          phase            = PH_ERROR;
          r.overflow_error = 1;
        end
      endcase
      r.committed_length = length_reg;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_label(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with no request outstanding", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      check_field("byte_class", 32'(want.byte_class), 32'(got.byte_class));
      check_field("field_end", 32'(want.field_end), 32'(got.field_end));
      check_field("headers_done", 32'(want.headers_done), 32'(got.headers_done));
      check_field("request_done", 32'(want.request_done), 32'(got.request_done));
      check_field("overflow_error", 32'(want.overflow_error), 32'(got.overflow_error));
      check_field("committed_length", 32'(want.committed_length),
                  32'(got.committed_length));
      checked++;
      if (want.headers_done) blocks_closed++;
      if (want.request_done) done_bytes++;
      if (want.overflow_error) overflow_bytes++;
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        start_request;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic [2:0]  byte_class;
  logic        field_end;
  logic        headers_done;
  logic        request_done;
  logic        overflow_error;
  logic [30:0] committed_length;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  request_labeler labeler;
  logic [8:0]     stream_q[$];   // {start, byte}
  bit             start_next;
  bit             calm_in;
  bit             calm_out;
  int             requests;
  int             settings;
  int unsigned    cycles;

  http_request_stream_parser u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .start_request    (start_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .byte_class       (byte_class),
    .field_end        (field_end),
    .headers_done     (headers_done),
    .request_done     (request_done),
    .overflow_error   (overflow_error),
    .committed_length (committed_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d labels still owed", $time, labeler.expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Requests accepted at this edge are predicted; results accepted are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) labeler.label_byte(data_byte, start_request);
      if (out_valid && !out_stall)
        labeler.compare_label({out_byte, byte_class, field_end, headers_done,
                               request_done, overflow_error, committed_length});
    end
  end

  // Receiver: random hold-off before each result, with calm stretches.
  initial begin : out_side
    int hold;
    out_stall <= 1'b0;
    calm_out = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void push_byte(logic [7:0] b);
    stream_q.push_back({start_next, b});
    start_next = 1'b0;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
    return v;
  endfunction

  // Mostly short fields; near small limits, sometimes exactly at or one past the limit.
  function automatic int field_len(logic [15:0] lim);
    int top;
    top = (lim > 16'd13) ? 12 : int'(lim) - 1;
    if (lim <= 16'd40 && $urandom_range(0, 7) == 0) return int'(lim) - 1 + $urandom_range(0, 1);
    return $urandom_range(0, top);
  endfunction

  function automatic void add_field(logic [7:0] term, int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) push_byte(CH_CR);
      push_byte(byte_other_than(term, CH_CR, CH_CR));
    end
    if (term == CH_LF && $urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(term);
  endfunction

  function automatic void add_line_end();
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  function automatic void add_request();
    int     body_len;
    int     n;
    int     pos;
    int     v;
    string  s;
    body_len   = 0;
    start_next = 1'b1;
    add_field(CH_SPACE, field_len(labeler.method_lim));
    add_field(CH_SPACE, field_len(labeler.path_lim));
    add_field(CH_LF, field_len(labeler.proto_lim));
    n = $urandom_range(0, 3);
    for (int h = 0; h < n; h++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 6)) push_byte(byte_other_than(CH_COLON, CH_CR, CH_LF));
          push_byte(CH_COLON);
          repeat ($urandom_range(0, 6)) push_byte(byte_other_than(CH_CR, CH_LF, CH_LF));
        end
        2, 3, 4: begin
          v = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
          push_text("Content-Length:");
          repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          if ($urandom_range(0, 2) == 0) push_byte(CH_PLUS);
          push_text($sformatf("%0d", v));
          if ($urandom_range(0, 3) == 0) push_text(" ;q=1");
          body_len = v;
        end
        5: begin
          push_text("Content-Length: -");
          push_text($sformatf("%0d", $urandom_range(1, 99)));
          body_len = 0;
        end
        6: begin
          // far past 2^31-1, value saturates
          push_text("Content-Length:9");
          repeat ($urandom_range(9, 11)) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
          body_len = int'(LEN_MAX);
        end
        7: begin
          s = "Content-Length";
          case ($urandom_range(0, 2))
            0: s = s.substr(0, 12);
            1: begin
              pos = $urandom_range(0, 13);
              if (pos == 7) pos = 0;
              s[pos] = s[pos] ^ 8'h20;
            end
            default: s = {s, "s"};
          endcase
          push_text(s);
          push_text(":5");
        end
        8: repeat ($urandom_range(1, 6)) push_byte(byte_other_than(CH_COLON, CH_CR, CH_LF));
        default: begin
          push_text("Content-Length:");
          repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
          body_len = 0;
        end
      endcase
      add_line_end();
    end
    add_line_end();
    n = (body_len > 24) ? $urandom_range(1, 6) : body_len + $urandom_range(0, 3);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
    requests++;
  endfunction

  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_request <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_stream();
    logic [8:0] item;
    while (stream_q.size() != 0) begin
      item = stream_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  // Drop valid and wait until every owed label has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (labeler.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_limits(logic [15:0] m, logic [15:0] p, logic [15:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_METHOD_LIMIT;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= REG_PATH_LIMIT;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= REG_PROTOCOL_LIMIT;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    labeler.set_limit(REG_METHOD_LIMIT, m);
    labeler.set_limit(REG_PATH_LIMIT, p);
    labeler.set_limit(REG_PROTOCOL_LIMIT, r);
    settings++;
  endtask

  task automatic random_traffic(int budget);
    int sent;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick    = $urandom_range(0, 9);
      calm_in = ($urandom_range(0, 4) == 0);
      if (pick == 0) begin
        repeat ($urandom_range(1, 8)) begin
          start_next = ($urandom_range(0, 3) == 0);
          push_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        add_request();
        // cut the request short; the next one restarts the parser
        if (pick == 1) begin
          pick = $urandom_range(1, stream_q.size());
          while (stream_q.size() > pick) void'(stream_q.pop_back());
        end
      end
      sent += stream_q.size();
      drain_stream();
    end
  endtask

  initial begin
    labeler = new();
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    data_byte     <= '0;
    start_request <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_METHOD_LIMIT;
    cfg_data      <= '0;
    cycles        = 0;
    calm_in       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest limits: one character per field, then overflow and empty fields.
    apply_limits(16'd2, 16'd2, 16'd2);
    start_next = 1'b1;
    push_byte("G");
    push_byte(CH_SPACE);
    push_byte("/");
    push_byte(CH_SPACE);
    push_byte(CH_CR);
    push_byte("H");
    push_byte(CH_LF);
    push_text("k:1");
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);      // empty line, no length: request finishes here
    push_byte(8'hff);      // after completion
    start_next = 1'b1;
    push_byte(8'h00);
    push_byte("x");        // second method char overflows
    push_byte(CH_SPACE);
    start_next = 1'b1;
    push_byte(CH_SPACE);
    push_byte(CH_SPACE);
    push_byte(CH_LF);
    push_byte(CH_LF);
    drain_stream();

    settle();
    apply_limits(16'd65535, 16'd65535, 16'd65535);
    random_traffic(260);
    settle();
    apply_limits(METHOD_LIMIT_RST, PATH_LIMIT_RST, PROTOCOL_LIMIT_RST);
    random_traffic(260);
    settle();
    apply_limits(16'd5, 16'd9, 16'd9);
    random_traffic(260);
    settle();
    apply_limits(16'd3, 16'd2, 16'd4);
    random_traffic(260);
    settle();
    repeat (10) @(posedge clk);

    $display("Labeled %0d bytes from %0d generated requests plus noise, %0d limit settings.",
             labeler.checked, requests, settings);
    $display("Header blocks closed %0d, Content-Length commits %0d, done bytes %0d, overflow %0d.",
             labeler.blocks_closed, labeler.commits, labeler.done_bytes,
             labeler.overflow_bytes);
    if (labeler.errors == 0 && labeler.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
